// File: rtl/lmssc_pkg.sv
// Package for the lift motor soft-start controller.
// Holds item command codes, host targets, register indexes and reset values.
// No dependencies; imported by the controller top level.
package lmssc_pkg;

    // Field widths fixed by the item format
    localparam int unsigned CmdW   = 2;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned DutyW  = 8;
    localparam int unsigned MsW    = 16;
    localparam int unsigned AddrW  = 5;
    localparam int unsigned DataW  = 32;
    localparam int unsigned RegIdxW = 3;

    // Item commands
    localparam logic [CmdW-1:0] CMD_BUTTON_POLL = 2'd0;
    localparam logic [CmdW-1:0] CMD_RAMP_TICK   = 2'd1;
    localparam logic [CmdW-1:0] CMD_HOST_LIFT   = 2'd2;
    localparam logic [CmdW-1:0] CMD_NONE        = 2'd3;

    // Host lift targets; the spare code acts as stop
    localparam logic [1:0] HOST_UP   = 2'd0;
    localparam logic [1:0] HOST_DOWN = 2'd1;
    localparam logic [1:0] HOST_STOP = 2'd2;

    // Register indexes (byte address is 4 * index)
    localparam logic [RegIdxW-1:0] REG_START_SPEED  = 3'd0;
    localparam logic [RegIdxW-1:0] REG_TARGET_SPEED = 3'd1;
    localparam logic [RegIdxW-1:0] REG_RAMP_STEP    = 3'd2;
    localparam logic [RegIdxW-1:0] REG_LIMIT_HOLD   = 3'd3;
    localparam logic [RegIdxW-1:0] REG_IDLE_TIMEOUT = 3'd4;

    // Register reset values
    localparam logic [DutyW-1:0] START_SPEED_RST  = 8'd100;
    localparam logic [DutyW-1:0] TARGET_SPEED_RST = 8'd255;
    localparam logic [DutyW-1:0] RAMP_STEP_RST    = 8'd6;
    localparam logic [MsW-1:0]   LIMIT_HOLD_RST   = 16'd1000;
    localparam logic [MsW-1:0]   IDLE_TIMEOUT_RST = 16'd1000;

    // Motion state carried between transactions
    typedef struct packed {
        logic             enabled;
        logic             down;
        logic [DutyW-1:0] duty;
        logic             ramp_active;
        logic             ramp_complete;
    } motor_state_t;

endpackage

// File: rtl/lift_motor_soft_start_control.sv
// Lift motor soft-start controller: gating, limit hold windows, duty ramp.
// Depends on lmssc_pkg for codes, register indexes and reset values.
//
// Pipeline: a transaction passes from the input register to the result
// register; a stalled result register holds it in the input register.
// One item per cycle while out_ready is high, set by the single
// state-update pass between the input and result registers.
// Reset (rst_n low, asynchronous): registers take their reset values, the
// motor is stopped and both pipeline registers are empty.
module lift_motor_soft_start_control
    import lmssc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // APB-style configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrW-1:0]     paddr,
    input  logic [DataW-1:0]     pwdata,
    output logic [DataW-1:0]     prdata,
    output logic                 pready,
    // Input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CmdW-1:0]      cmd,
    input  logic [TimeW-1:0]     now_ms,
    input  logic                 up_pressed,
    input  logic                 down_pressed,
    input  logic                 emergency_ok,
    input  logic                 auto_mode,
    input  logic                 joystick_mode,
    input  logic                 upper_limit,
    input  logic                 lower_limit,
    input  logic [1:0]           host_target,
    // Result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DutyW-1:0]     pwm_duty,
    output logic                 drive_on,
    output logic                 drive_down,
    output logic                 ramp_finished
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DutyW-1:0]   start_speed_reg;
    logic [DutyW-1:0]   target_speed_reg;
    logic [DutyW-1:0]   ramp_step_reg;
    logic [MsW-1:0]     limit_hold_reg;
    logic [MsW-1:0]     idle_timeout_reg;
    logic               cfg_write;
    logic [RegIdxW-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[AddrW-1:2];

    // Write the addressed register; addresses past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_speed_reg  <= START_SPEED_RST;
            target_speed_reg <= TARGET_SPEED_RST;
            ramp_step_reg    <= RAMP_STEP_RST;
            limit_hold_reg   <= LIMIT_HOLD_RST;
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_START_SPEED:  start_speed_reg  <= pwdata[DutyW-1:0];
                REG_TARGET_SPEED: target_speed_reg <= pwdata[DutyW-1:0];
                REG_RAMP_STEP:    ramp_step_reg    <= pwdata[DutyW-1:0];
                REG_LIMIT_HOLD:   limit_hold_reg   <= pwdata[MsW-1:0];
                REG_IDLE_TIMEOUT: idle_timeout_reg <= pwdata[MsW-1:0];
                default:          ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (cfg_idx)
            REG_START_SPEED:  prdata = {{(DataW-DutyW){1'b0}}, start_speed_reg};
            REG_TARGET_SPEED: prdata = {{(DataW-DutyW){1'b0}}, target_speed_reg};
            REG_RAMP_STEP:    prdata = {{(DataW-DutyW){1'b0}}, ramp_step_reg};
            REG_LIMIT_HOLD:   prdata = {{(DataW-MsW){1'b0}}, limit_hold_reg};
            REG_IDLE_TIMEOUT: prdata = {{(DataW-MsW){1'b0}}, idle_timeout_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and pipeline control
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic [CmdW-1:0]   cmd_reg;
    logic [TimeW-1:0]  now_reg;
    logic              up_reg, dn_reg, emg_reg, auto_reg, joy_reg, mx_reg, mn_reg;
    logic [1:0]        tgt_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              take_in;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign take_in  = in_valid && in_ready;

    // Track occupancy of the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take_in)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Capture the transaction payload
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            cmd_reg  <= cmd;
            now_reg  <= now_ms;
            up_reg   <= up_pressed;
            dn_reg   <= down_pressed;
            emg_reg  <= emergency_ok;
            auto_reg <= auto_mode;
            joy_reg  <= joystick_mode;
            mx_reg   <= upper_limit;
            mn_reg   <= lower_limit;
            tgt_reg  <= host_target;
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    motor_state_t     motor_reg, motor_next;
    logic [TimeW-1:0] last_act_reg, last_act_next;
    logic             btn_prev_max_reg, btn_prev_max_next;
    logic             btn_prev_min_reg, btn_prev_min_next;
    logic [TimeW-1:0] btn_max_hit_reg, btn_max_hit_next;
    logic [TimeW-1:0] btn_min_hit_reg, btn_min_hit_next;
    logic             host_prev_max_reg, host_prev_max_next;
    logic             host_prev_min_reg, host_prev_min_next;
    logic [TimeW-1:0] host_max_hit_reg, host_max_hit_next;
    logic [TimeW-1:0] host_min_hit_reg, host_min_hit_next;

    // Elapsed times, modulo 2^32
    logic [TimeW-1:0] btn_max_hit_upd, btn_min_hit_upd;
    logic [TimeW-1:0] host_max_hit_upd, host_min_hit_upd;
    logic [TimeW-1:0] btn_max_age, btn_min_age, host_max_age, host_min_age, idle_age;
    logic             btn_hold_max, btn_hold_min, host_hold_max, host_hold_min;
    logic             btn_allowed, idle_expired;
    logic             run_req, run_down, stop_req;
    logic [DutyW:0]   duty_sum;

    // Button path: latch limit rising edges, drop a mark while its limit is set and its button is not pushed
    always_comb
    begin
        btn_max_hit_upd = (mx_reg && !btn_prev_max_reg) ? now_reg : btn_max_hit_reg;
        btn_min_hit_upd = (mn_reg && !btn_prev_min_reg) ? now_reg : btn_min_hit_reg;
        if (mx_reg && !up_reg)
        begin
            btn_max_hit_upd = '0;
        end
        if (mn_reg && !dn_reg)
        begin
            btn_min_hit_upd = '0;
        end
    end

    // Host path: latch limit rising edges
    assign host_max_hit_upd = (mx_reg && !host_prev_max_reg) ? now_reg : host_max_hit_reg;
    assign host_min_hit_upd = (mn_reg && !host_prev_min_reg) ? now_reg : host_min_hit_reg;

    assign btn_max_age  = now_reg - btn_max_hit_upd;
    assign btn_min_age  = now_reg - btn_min_hit_upd;
    assign host_max_age = now_reg - host_max_hit_upd;
    assign host_min_age = now_reg - host_min_hit_upd;
    assign idle_age     = now_reg - last_act_reg;

    assign btn_hold_max  = up_reg && mx_reg
                        && (btn_max_age < {{(TimeW-MsW){1'b0}}, limit_hold_reg});
    assign btn_hold_min  = dn_reg && mn_reg
                        && (btn_min_age < {{(TimeW-MsW){1'b0}}, limit_hold_reg});
    assign host_hold_max = (tgt_reg == HOST_UP) && mx_reg
                        && (host_max_age < {{(TimeW-MsW){1'b0}}, limit_hold_reg});
    assign host_hold_min = (tgt_reg == HOST_DOWN) && mn_reg
                        && (host_min_age < {{(TimeW-MsW){1'b0}}, limit_hold_reg});
    assign btn_allowed   = emg_reg && !auto_reg && joy_reg;
    assign idle_expired  = idle_age > {{(TimeW-MsW){1'b0}}, idle_timeout_reg};
    assign duty_sum      = {1'b0, motor_reg.duty} + {1'b0, ramp_step_reg};

    // Next state for the transaction in the input register
    always_comb
    begin
        motor_next         = motor_reg;
        last_act_next      = last_act_reg;
        btn_prev_max_next  = btn_prev_max_reg;
        btn_prev_min_next  = btn_prev_min_reg;
        btn_max_hit_next   = btn_max_hit_reg;
        btn_min_hit_next   = btn_min_hit_reg;
        host_prev_max_next = host_prev_max_reg;
        host_prev_min_next = host_prev_min_reg;
        host_max_hit_next  = host_max_hit_reg;
        host_min_hit_next  = host_min_hit_reg;
        run_req            = 1'b0;
        run_down           = 1'b0;
        stop_req           = 1'b0;

        unique case (cmd_reg)
            CMD_BUTTON_POLL:
            begin
                btn_prev_max_next = mx_reg;
                btn_prev_min_next = mn_reg;
                btn_max_hit_next  = btn_max_hit_upd;
                btn_min_hit_next  = btn_min_hit_upd;
                priority if (up_reg && !dn_reg && btn_allowed && (!mx_reg || btn_hold_max))
                begin
                    run_req = 1'b1;
                end
                else if (dn_reg && !up_reg && btn_allowed && (!mn_reg || btn_hold_min))
                begin
                    run_req  = 1'b1;
                    run_down = 1'b1;
                end
                else if (idle_expired || !emg_reg)
                begin
                    stop_req      = 1'b1;
                    last_act_next = now_reg;
                end
                else
                begin
                end
            end
            CMD_RAMP_TICK:
            begin
                if (motor_reg.ramp_active && motor_reg.enabled)
                begin
                    if (duty_sum > {1'b0, target_speed_reg})
                    begin
                        motor_next.duty          = target_speed_reg;
                        motor_next.ramp_active   = 1'b0;
                        motor_next.ramp_complete = 1'b1;
                    end
                    else
                    begin
                        motor_next.duty = duty_sum[DutyW-1:0];
                    end
                end
            end
            CMD_HOST_LIFT:
            begin
                last_act_next = now_reg;
                // A pressed button leaves the host path untouched
                if (!(up_reg || dn_reg))
                begin
                    host_prev_max_next = mx_reg;
                    host_prev_min_next = mn_reg;
                    host_max_hit_next  = host_max_hit_upd;
                    host_min_hit_next  = host_min_hit_upd;
                    priority if ((tgt_reg == HOST_UP) && (!mx_reg || host_hold_max)
                                 && emg_reg && joy_reg)
                    begin
                        run_req = 1'b1;
                    end
                    else if ((tgt_reg == HOST_DOWN) && (!mn_reg || host_hold_min)
                             && emg_reg && joy_reg)
                    begin
                        run_req  = 1'b1;
                        run_down = 1'b1;
                    end
                    else
                    begin
                        stop_req = 1'b1;
                    end
                end
            end
            CMD_NONE:
            begin
            end
            default:
            begin
            end
        endcase

        // Start: set direction, begin a ramp only from rest
        if (run_req)
        begin
            motor_next.down    = run_down;
            motor_next.enabled = 1'b1;
            if (!motor_reg.ramp_active && !motor_reg.ramp_complete)
            begin
                motor_next.duty          = start_speed_reg;
                motor_next.ramp_active   = 1'b1;
                motor_next.ramp_complete = 1'b0;
            end
        end

        // Stop: drop drive and clear the ramp
        if (stop_req)
        begin
            motor_next.enabled       = 1'b0;
            motor_next.duty          = '0;
            motor_next.ramp_active   = 1'b0;
            motor_next.ramp_complete = 1'b0;
        end
    end

    // Advance the state as each transaction passes to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_reg         <= '0;
            last_act_reg      <= '0;
            btn_prev_max_reg  <= 1'b1;
            btn_prev_min_reg  <= 1'b1;
            btn_max_hit_reg   <= '0;
            btn_min_hit_reg   <= '0;
            host_prev_max_reg <= 1'b1;
            host_prev_min_reg <= 1'b1;
            host_max_hit_reg  <= '0;
            host_min_hit_reg  <= '0;
        end
        else if (advance)
        begin
            motor_reg         <= motor_next;
            last_act_reg      <= last_act_next;
            btn_prev_max_reg  <= btn_prev_max_next;
            btn_prev_min_reg  <= btn_prev_min_next;
            btn_max_hit_reg   <= btn_max_hit_next;
            btn_min_hit_reg   <= btn_min_hit_next;
            host_prev_max_reg <= host_prev_max_next;
            host_prev_min_reg <= host_prev_min_next;
            host_max_hit_reg  <= host_max_hit_next;
            host_min_hit_reg  <= host_min_hit_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [DutyW-1:0] duty_out_reg;
    logic             drive_on_reg, drive_down_reg, ramp_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the state reached after the transaction
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            duty_out_reg   <= motor_next.duty;
            drive_on_reg   <= motor_next.enabled;
            drive_down_reg <= motor_next.down;
            ramp_done_reg  <= motor_next.ramp_complete;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pwm_duty      = duty_out_reg;
    assign drive_on      = drive_on_reg;
    assign drive_down    = drive_down_reg;
    assign ramp_finished = ramp_done_reg;

`ifndef SYNTHESIS
    // A ramp cannot be running and finished at once
    a_ramp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(motor_reg.ramp_active && motor_reg.ramp_complete))
        else $error("ramp running and finished together");

    // A stopped motor carries no duty and no ramp
    a_stopped_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !motor_reg.enabled |-> (motor_reg.duty == '0) && !motor_reg.ramp_active
                               && !motor_reg.ramp_complete)
        else $error("stopped motor keeps duty or ramp state");

    // A held transaction stays in the input register
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(cmd_reg) && $stable(now_reg))
        else $error("input transaction lost while stalled");

    // Each advanced transaction produces a result
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced transaction gave no result");
`endif

endmodule
